// ===== rtl/rtd_pkg.sv =====
// ----------------------------------------------------------------------------
// RTD conversion package
// Widths, fixed-point constants and result type shared by the RTD converter.
// ----------------------------------------------------------------------------
package rtd_pkg;

  localparam int CODE_BITS = 15;
  localparam int RAW_W     = 16;
  localparam int CODE_W    = RAW_W - 1;
  localparam int RREF_W    = 16;
  localparam int R0_W      = 14;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int T_W       = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_RREF = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R0   = 1'd1;

  localparam logic [RREF_W-1:0] RREF_RST = 16'd430;
  localparam logic [R0_W-1:0]   R0_RST   = 14'd100;

  // Resistance ratio division: x = P * 2^SHIFT / R0, four quotient bits a stage.
  localparam int P_W      = CODE_W + RREF_W;
  localparam int SHIFT    = 32 - CODE_BITS;
  localparam int X_W      = P_W + SHIFT;
  localparam int DIV_STEP = 4;
  localparam int DIV_ST   = (X_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DVD_W    = DIV_ST * DIV_STEP;

  // Radicand in Q32, scaled by 1e14.
  localparam logic [27:0]        K4B      = 28'd231000000;
  localparam logic signed [65:0] RAD_BASE = 66'sh05B0B823900000000;
  localparam logic signed [X_W:0] X_ONE   = (X_W + 1)'(64'd1 << 32);
  localparam logic signed [X_W:0] Y_MAX   = (X_W + 1)'(64'd7 << 32);

  // Square root, two root bits a stage.
  localparam int SQ_STEP = 2;
  localparam int SQ_ST   = 32 / SQ_STEP;

  // Quadratic branch scaling.
  localparam logic [31:0] LIM   = 32'd2561343488;
  localparam logic [35:0] Q_RND = 36'd7392;
  localparam logic [35:0] Q_SAT = 36'd3875536896;
  localparam logic [26:0] C231  = 27'd74371729;

  // Polynomial branch.
  localparam int H_ST  = 5;
  localparam int ACC_W = 40;
  localparam logic signed [23:0] POLY_C [0:5] = '{
    -24'sd2420200, 24'sd2222800, 24'sd258590, -24'sd48260, -24'sd28183, 24'sd15243
  };
  localparam logic signed [ACC_W-1:0] ACC_INIT = ACC_W'(POLY_C[5]) <<< 16;
  localparam logic signed [40:0] P_RND = 41'sd1280000;
  localparam logic signed [40:0] P_OFS = 41'sd163840000;
  localparam logic [29:0]        C625  = 30'd879609303;
  localparam logic signed [21:0] P_KOFS = 22'sd262144;

  localparam logic signed [T_W-1:0] T_MAX = 19'sd262143;
  localparam logic signed [T_W-1:0] T_MIN = -19'sd65536;

  localparam int N_ST = 2 + DIV_ST + 3 + SQ_ST + 4 + 2 * H_ST + 3;

  typedef struct packed {
    logic signed [T_W-1:0] temperature_q8;
    logic                  fault_bit;
    logic                  low_range_used;
    logic                  out_of_range;
  } res_t;

endpackage

// ===== rtl/rtd_if.sv =====
// ----------------------------------------------------------------------------
// RTD converter channels
// Input word channel and result word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtd_in_if import rtd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_word;

  modport source (output valid, output raw_word, input ready);
  modport sink   (input valid, input raw_word, output ready);
endinterface

interface rtd_out_if import rtd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [T_W-1:0] temperature_q8;
  logic                  fault_bit;
  logic                  low_range_used;
  logic                  out_of_range;

  modport source (output valid, output temperature_q8, output fault_bit,
                  output low_range_used, output out_of_range, input ready);
  modport sink   (input valid, input temperature_q8, input fault_bit,
                  input low_range_used, input out_of_range, output ready);
endinterface

// ===== rtl/rtd_code_to_temperature.sv =====
// ----------------------------------------------------------------------------
// RTD code to temperature converter
// Inverse Callendar-Van Dusen conversion of an RTD ratio word, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  in_i     sink       raw_word: ratio code in bits 15..1, fault flag in bit 0
//  out_o    source     temperature_q8, fault_bit, low_range_used, out_of_range
//  cfg      write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// One word enters every cycle unless a stalled output holds the pipeline.
// The pipeline holds the ratio divider, four quotient bits a stage, and the
// square root, two root bits a stage.
// Reset clears the valid bits and loads the default resistor values.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rtd_code_to_temperature import rtd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  rtd_in_if.sink               in_i,
  rtd_out_if.source            out_o
);

  typedef struct packed {
    logic [R0_W-1:0]  rem;
    logic [DVD_W-1:0] dvd;
    logic [DVD_W-1:0] quo;
    logic [R0_W-1:0]  r0;
  } div_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  typedef struct packed {
    logic        fault;
    logic [23:0] x24;
    logic        neg;
    logic        low;
    logic        qsat;
    logic [17:0] qt;
  } side_t;

  function automatic div_t div_stage(div_t a);
    div_t            b;
    logic [R0_W:0]   t;
    b = a;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {b.rem, b.dvd[DVD_W-1]};
      if (t >= {1'b0, b.r0}) begin
        b.rem = R0_W'(t - {1'b0, b.r0});
        b.quo = {b.quo[DVD_W-2:0], 1'b1};
      end else begin
        b.rem = t[R0_W-1:0];
        b.quo = {b.quo[DVD_W-2:0], 1'b0};
      end
      b.dvd = {b.dvd[DVD_W-2:0], 1'b0};
    end
    return b;
  endfunction

  function automatic sq_t sq_stage(sq_t a);
    sq_t         b;
    logic [35:0] t;
    logic [35:0] trial;
    b = a;
    for (int i = 0; i < SQ_STEP; i++) begin
      t     = {b.rem, b.rad[63:62]};
      trial = {2'b00, b.root, 2'b01};
      if (t >= trial) begin
        b.rem  = 34'(t - trial);
        b.root = {b.root[30:0], 1'b1};
      end else begin
        b.rem  = t[33:0];
        b.root = {b.root[30:0], 1'b0};
      end
      b.rad = {b.rad[61:0], 2'b00};
    end
    return b;
  endfunction

  logic              adv;
  logic [N_ST-1:0]   vld_q;
  logic [RREF_W-1:0] rref_q;
  logic [R0_W-1:0]   r0_q;

  assign adv         = !vld_q[N_ST-1] || out_o.ready;
  assign in_i.ready  = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rref_q <= RREF_RST;
      r0_q   <= R0_RST;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[N_ST-2:0], in_i.valid};
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RREF: rref_q <= cfg_data_i[RREF_W-1:0];
          CFG_R0:   r0_q   <= cfg_data_i[R0_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Input word and ratio product.
  logic [RAW_W-1:0] raw_q;
  logic [P_W-1:0]   p_q;
  logic [R0_W-1:0]  r0e_q;
  side_t            s1_q;
  side_t            s1_d;

  always_comb begin
    s1_d       = '0;
    s1_d.fault = raw_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      raw_q <= in_i.raw_word;
      p_q   <= P_W'(raw_q[RAW_W-1:1]) * P_W'(rref_q);
      r0e_q <= (r0_q == '0) ? R0_W'(1) : r0_q;
      s1_q  <= s1_d;
    end
  end

  // Ratio divider.
  div_t  div_q  [DIV_ST];
  side_t dside_q[DIV_ST];

  for (genvar j = 0; j < DIV_ST; j++) begin : g_div
    div_t  d_in;
    side_t s_in;
    if (j == 0) begin : g_first
      assign d_in = '{rem: '0, dvd: DVD_W'({p_q, {SHIFT{1'b0}}}), quo: '0, r0: r0e_q};
      assign s_in = s1_q;
    end else begin : g_next
      assign d_in = div_q[j-1];
      assign s_in = dside_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[j]   <= div_stage(d_in);
        dside_q[j] <= s_in;
      end
    end
  end

  // Radicand.
  logic [X_W-1:0]       x;
  logic signed [X_W:0]  y;
  side_t                r1_d;
  side_t                r1_q;
  side_t                r2_q;
  side_t                r3_d;
  side_t                r3_q;
  logic [17:0]          yl_q;
  logic signed [17:0]   yh_q;
  logic [45:0]          pl_q;
  logic signed [46:0]   ph_q;
  logic signed [65:0]   prod;
  logic signed [65:0]   dval;
  logic [63:0]          rad_q;

  assign x    = div_q[DIV_ST-1].quo[X_W-1:0];
  assign y    = $signed({1'b0, x}) - X_ONE;
  assign prod = (66'(ph_q) <<< 18) + $signed({20'b0, pl_q});
  assign dval = RAD_BASE - prod;

  always_comb begin
    r1_d     = dside_q[DIV_ST-1];
    r1_d.x24 = x[31:8];
    r1_d.neg = y > Y_MAX;
    r3_d     = r2_q;
    r3_d.neg = r2_q.neg || dval[65];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yl_q  <= y[17:0];
      yh_q  <= $signed(y[35:18]);
      r1_q  <= r1_d;
      pl_q  <= 46'(K4B) * 46'(yl_q);
      ph_q  <= $signed({1'b0, K4B}) * yh_q;
      r2_q  <= r1_q;
      rad_q <= dval[63:0];
      r3_q  <= r3_d;
    end
  end

  // Square root.
  sq_t   sq_q  [SQ_ST];
  side_t sside_q[SQ_ST];

  for (genvar j = 0; j < SQ_ST; j++) begin : g_sq
    sq_t   q_in;
    side_t s_in;
    if (j == 0) begin : g_first
      assign q_in = '{rem: '0, root: '0, rad: rad_q};
      assign s_in = r3_q;
    end else begin : g_next
      assign q_in = sq_q[j-1];
      assign s_in = sside_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[j]    <= sq_stage(q_in);
        sside_q[j] <= s_in;
      end
    end
  end

  // Quadratic branch scaling.
  logic [31:0] s_root;
  logic [35:0] qn_q;
  logic [25:0] qm_q;
  logic [52:0] qprod_q;
  side_t       qa_d;
  side_t       qa_q;
  side_t       qb_d;
  side_t       qb_q;
  side_t       qc_q;
  side_t       qd_d;
  side_t       qd_q;

  assign s_root = sq_q[SQ_ST-1].root;

  always_comb begin
    qa_d      = sside_q[SQ_ST-1];
    qa_d.low  = s_root > LIM;
    qb_d      = qa_q;
    qb_d.qsat = qn_q >= Q_SAT;
    qd_d      = qc_q;
    qd_d.qt   = qprod_q[51:34];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qn_q    <= 36'({4'b0, 32'(LIM - s_root)}) * 36'd5 + Q_RND;
      qa_q    <= qa_d;
      qm_q    <= qn_q[31:6];
      qb_q    <= qb_d;
      qprod_q <= 53'(qm_q) * 53'(C231);
      qc_q    <= qb_q;
      qd_q    <= qd_d;
    end
  end

  // Polynomial fit, Horner steps of a multiply stage and an accumulate stage.
  logic signed [ACC_W-1:0] acc_q [H_ST];
  logic signed [44:0]      hph_q [H_ST];
  logic [43:0]             hpl_q [H_ST];
  side_t                   hsa_q [H_ST];
  side_t                   hsb_q [H_ST];

  for (genvar j = 0; j < H_ST; j++) begin : g_h
    logic signed [ACC_W-1:0] acc_in;
    side_t                   s_in;
    logic signed [65:0]      sum;
    if (j == 0) begin : g_first
      assign acc_in = ACC_INIT;
      assign s_in   = qd_q;
    end else begin : g_next
      assign acc_in = acc_q[j-1];
      assign s_in   = hsb_q[j-1];
    end
    assign sum = (66'(hph_q[j]) <<< 20) + $signed({22'b0, hpl_q[j]});
    always_ff @(posedge clk_i) begin
      if (adv) begin
        hph_q[j] <= $signed(acc_in[ACC_W-1:20]) * $signed({1'b0, s_in.x24});
        hpl_q[j] <= 44'(acc_in[19:0]) * 44'(s_in.x24);
        hsa_q[j] <= s_in;
        acc_q[j] <= ACC_W'(sum >>> 24) + (ACC_W'(POLY_C[H_ST-1-j]) <<< 16);
        hsb_q[j] <= hsa_q[j];
      end
    end
  end

  // Final scaling, selection and saturation.
  logic signed [40:0] fw;
  logic signed [40:0] fv;
  logic [28:0]        fu_q;
  logic [58:0]        fprod_q;
  side_t              f1_q;
  side_t              f2_q;
  logic signed [21:0] pt;
  res_t               res_d;
  res_t               res_q;

  assign fw = 41'(acc_q[H_ST-1]) + P_RND;
  assign fv = (fw >>> 12) + P_OFS;
  assign pt = $signed({2'b00, fprod_q[58:39]}) - P_KOFS;

  always_comb begin
    res_d.fault_bit      = f2_q.fault;
    res_d.low_range_used = f2_q.low && !f2_q.neg;
    res_d.out_of_range   = 1'b0;
    res_d.temperature_q8 = T_MAX;
    if (f2_q.neg) begin
      res_d.out_of_range = 1'b1;
    end else if (!f2_q.low) begin
      if (f2_q.qsat) begin
        res_d.out_of_range = 1'b1;
      end else begin
        res_d.temperature_q8 = $signed({1'b0, f2_q.qt});
      end
    end else if (pt > 22'(T_MAX)) begin
      res_d.out_of_range = 1'b1;
    end else if (pt < 22'(T_MIN)) begin
      res_d.out_of_range   = 1'b1;
      res_d.temperature_q8 = T_MIN;
    end else begin
      res_d.temperature_q8 = pt[T_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fu_q    <= fv[28:0];
      f1_q    <= hsb_q[H_ST-1];
      fprod_q <= 59'(fu_q) * 59'(C625);
      f2_q    <= f1_q;
      res_q   <= res_d;
    end
  end

  assign out_o.valid          = vld_q[N_ST-1];
  assign out_o.temperature_q8 = res_q.temperature_q8;
  assign out_o.fault_bit      = res_q.fault_bit;
  assign out_o.low_range_used = res_q.low_range_used;
  assign out_o.out_of_range   = res_q.out_of_range;

endmodule
